[rtl/nwes_pkg.sv]
// shared types and constants of the nand wordline error statistics block
package nwes_pkg;

    localparam int PAGE_BITS    = 11;
    localparam int SLOT_BITS    = 6;
    localparam int IDX_BITS     = 7;
    localparam int SUM_BITS     = 48;
    localparam int ERR_BITS     = 16;
    localparam int OUT_CNT_BITS = 32;

    localparam int SLOT_COLUMNS   = 34;
    localparam int SLOT_TOTAL     = 68;
    localparam int PAGE_LIMIT     = 1024;
    localparam int SLC_LOW_END    = 32;
    localparam int SLC_HIGH_END   = 960;
    localparam int UPPER_START    = 64;
    localparam int PAIR_SPLIT     = 126;
    localparam int PAIR_OFFSET    = 63;
    localparam int TOP_REGION     = 960;
    localparam int TOP_SLOT_BASE  = 32;
    localparam int MID_SLOT_BASE  = 2;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } nwes_op_t;

    typedef enum logic [1:0] {
        KIND_SLC   = 2'd0,
        KIND_LOWER = 2'd1,
        KIND_UPPER = 2'd2
    } nwes_kind_t;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [ERR_BITS-1:0] first_error;
        logic signed [ERR_BITS-1:0] second_error;
        logic                       read_row;
        logic [SLOT_BITS-1:0]       read_column;
    } nwes_req_t;

    typedef struct packed {
        logic [1:0]                 page_kind;
        logic [SLOT_BITS-1:0]       wordline_slot;
        logic                       slot_row;
        logic [OUT_CNT_BITS-1:0]    slot_count;
        logic signed [SUM_BITS-1:0] slot_sum;
        logic signed [ERR_BITS-1:0] slot_max;
        logic                       dropped;
    } nwes_rsp_t;

    // where a page lands in the slot table
    typedef struct packed {
        nwes_kind_t           kind;
        logic [SLOT_BITS-1:0] slot;
        logic                 row;
    } nwes_page_info_t;

endpackage

[rtl/nwes_if.sv]
// request and response channel interfaces
interface nwes_req_if;
    logic               valid;
    logic               ready;
    nwes_pkg::nwes_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nwes_rsp_if;
    logic               valid;
    logic               ready;
    nwes_pkg::nwes_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/nwes_page_map.sv]
// page classification and wordline slot mapping
module nwes_page_map (
    input  logic [9:0]                page,
    output nwes_pkg::nwes_page_info_t info
);
    import nwes_pkg::*;

    logic       is_upper;
    logic       is_slc;
    logic [9:0] q;
    logic [9:0] top_off;

    always_comb
    begin
        is_upper = (page[0] == 1'b0) && (page >= 10'(UPPER_START));
        is_slc   = (page < 10'(SLC_LOW_END)) || (page > 10'(SLC_HIGH_END));

        if (is_upper)
            info.kind = KIND_UPPER;
        else if (is_slc)
            info.kind = KIND_SLC;
        else
            info.kind = KIND_LOWER;

        // upper pages share the wordline of their paired lower page
        q = page;
        if (is_upper)
            q = (page < 10'(PAIR_SPLIT)) ? (page >> 1) : (page - 10'(PAIR_OFFSET));

        top_off = q - 10'(TOP_REGION);
        if (q < 10'(UPPER_START))
            info.slot = 6'(q >> 4);
        else if (q < 10'(TOP_REGION))
            info.slot = 6'(q >> 5) + 6'(MID_SLOT_BASE);
        else
            info.slot = 6'(top_off >> 5) + 6'(TOP_SLOT_BASE);

        info.row = is_upper;
    end

endmodule

[rtl/nwes_slot_update.sv]
// saturating count, sum and maximum update of one slot
module nwes_slot_update #(
    parameter int COUNT_BITS = 32
) (
    input  logic                                   hit,
    input  logic [COUNT_BITS-1:0]                  cnt_in,
    input  logic signed [nwes_pkg::SUM_BITS-1:0]   sum_in,
    input  logic signed [nwes_pkg::ERR_BITS-1:0]   max_in,
    input  logic signed [nwes_pkg::ERR_BITS-1:0]   total,
    output logic [COUNT_BITS-1:0]                  cnt_out,
    output logic signed [nwes_pkg::SUM_BITS-1:0]   sum_out,
    output logic signed [nwes_pkg::ERR_BITS-1:0]   max_out
);
    import nwes_pkg::*;

    logic [COUNT_BITS-1:0]        cnt_base;
    logic signed [SUM_BITS-1:0]   sum_base;
    logic signed [ERR_BITS-1:0]   max_base;
    logic signed [SUM_BITS:0]     sum_wide;

    always_comb
    begin
        // a slot that is not valid starts from zero
        cnt_base = hit ? cnt_in : '0;
        sum_base = hit ? sum_in : '0;
        max_base = hit ? max_in : '0;

        cnt_out = (cnt_base != '1) ? cnt_base + 1'b1 : cnt_base;

        sum_wide = {sum_base[SUM_BITS-1], sum_base}
                 + {{(SUM_BITS+1-ERR_BITS){total[ERR_BITS-1]}}, total};
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
            sum_out = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        else
            sum_out = sum_wide[SUM_BITS-1:0];

        max_out = (max_base < total) ? total : max_base;
    end

endmodule

[rtl/nwes_top_level_placeholder_unused.sv]
// page counter helper: codeword and page counting for the statistics block
module nwes_page_count #(
    parameter int CODEWORDS_PER_PAGE = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           restart,
    input  logic                           advance,
    output logic [nwes_pkg::PAGE_BITS-1:0] page
);
    import nwes_pkg::*;

    localparam int CW_BITS = (CODEWORDS_PER_PAGE > 1) ? $clog2(CODEWORDS_PER_PAGE) : 1;

    logic [CW_BITS-1:0]   cw_reg,   cw_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;

    always_comb
    begin
        cw_next   = cw_reg;
        page_next = page_reg;
        if (restart)
        begin
            cw_next   = '0;
            page_next = '0;
        end
        else if (advance)
        begin
            // advance is only raised below the page limit, so the page count stops at that limit
            if (cw_reg == CW_BITS'(CODEWORDS_PER_PAGE - 1))
            begin
                cw_next   = '0;
                page_next = page_reg + 1'b1;
            end
            else
            begin
                cw_next = cw_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg   <= '0;
            page_reg <= '0;
        end
        else
        begin
            cw_reg   <= cw_next;
            page_reg <= page_next;
        end
    end

    assign page = page_reg;

endmodule

[rtl/nand_wordline_error_stats.sv]
// top level of the nand wordline error statistics block
//
//  channel | dir | payload                                              | role
//  --------+-----+------------------------------------------------------+-----------------------
//  req     | in  | op, first_error, second_error, read_row, read_column | sample, start, clear, read
//  rsp     | out | page_kind, wordline_slot, slot_row, slot_count,      | one response per request
//          |     | slot_sum, slot_max, dropped                          |
//
// one request per cycle while not stalled; two registers deep, stage 1 then rsp, which sets rsp.valid
// slot memory is read at accept and written when the request moves into the response
// register; a write to the same slot by the request just ahead is forwarded into the next
// request's operands
// a full response register holds the pipe only while rsp.ready is low
// reset clears counters, valid bits and handshake state; the slot memory needs no
// clearing pass because each entry has a valid bit
module nand_wordline_error_stats #(
    parameter int CODEWORDS_PER_PAGE = 4,
    parameter int COUNT_BITS         = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    nwes_req_if.sink   req,
    nwes_rsp_if.source rsp
);
    import nwes_pkg::*;

    // ---------------------------------------------------------------------
    // handshake and pipeline control
    // ---------------------------------------------------------------------
    logic accept;
    logic out_free;
    logic s1_commit;
    logic s1_write;

    logic s1_valid_reg, s1_valid_next;
    logic rsp_valid_reg, rsp_valid_next;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || out_free;
    assign accept    = req.valid && req.ready;
    assign s1_commit = s1_valid_reg && out_free;

    // ---------------------------------------------------------------------
    // page tracking
    // ---------------------------------------------------------------------
    logic [PAGE_BITS-1:0] page;
    logic                 page_over;
    nwes_page_info_t      pinfo;
    nwes_op_t             a_op;

    assign a_op      = nwes_op_t'(req.data.op);
    assign page_over = (page >= PAGE_BITS'(PAGE_LIMIT));

    nwes_page_count #(
        .CODEWORDS_PER_PAGE (CODEWORDS_PER_PAGE)
    ) u_page_count (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (accept && (a_op == OP_START)),
        .advance (accept && (a_op == OP_SAMPLE) && !page_over),
        .page    (page)
    );

    nwes_page_map u_page_map (
        .page (page[9:0]),
        .info (pinfo)
    );

    // ---------------------------------------------------------------------
    // accept stage: slot index, valid lookup, memory read
    // ---------------------------------------------------------------------
    logic [SLOT_TOTAL-1:0]      slot_valid_reg, slot_valid_next;
    logic [IDX_BITS-1:0]        a_idx;
    logic                       a_hit;
    logic                       a_col_ok;
    logic [IDX_BITS-1:0]        a_read_idx;
    logic [1:0]                 a_kind;
    logic [SLOT_BITS-1:0]       a_slot;
    logic                       a_row;
    logic signed [ERR_BITS-1:0] a_total;
    logic                       a_drop;

    assign a_col_ok   = (req.data.read_column < SLOT_BITS'(SLOT_COLUMNS));
    assign a_read_idx = req.data.read_row
                      ? IDX_BITS'(SLOT_COLUMNS) + IDX_BITS'(req.data.read_column)
                      : IDX_BITS'(req.data.read_column);
    // pair total wraps to 16 bits
    assign a_total    = req.data.first_error + req.data.second_error;

    always_comb
    begin
        a_idx  = '0;
        a_hit  = 1'b0;
        a_slot = '0;
        a_row  = 1'b0;
        a_drop = 1'b0;
        a_kind = page_over ? KIND_SLC : pinfo.kind;
        unique case (a_op)
            OP_SAMPLE:
            begin
                if (page_over)
                begin
                    a_drop = 1'b1;
                    a_kind = KIND_SLC;
                end
                else
                begin
                    a_slot = pinfo.slot;
                    a_row  = pinfo.row;
                    a_idx  = pinfo.row ? IDX_BITS'(SLOT_COLUMNS) + IDX_BITS'(pinfo.slot)
                                       : IDX_BITS'(pinfo.slot);
                    a_hit  = slot_valid_reg[a_idx];
                end
            end
            OP_START:
            begin
                // page returns to zero, which is always an slc page
                a_kind = KIND_SLC;
            end
            OP_CLEAR:
            begin
            end
            OP_READ:
            begin
                a_slot = req.data.read_column;
                a_row  = req.data.read_row;
                if (a_col_ok)
                begin
                    a_idx = a_read_idx;
                    a_hit = slot_valid_reg[a_read_idx];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (accept)
        begin
            if (a_op == OP_CLEAR)
                slot_valid_next = '0;
            else if ((a_op == OP_SAMPLE) && !page_over)
                slot_valid_next[a_idx] = 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // slot memory
    // ---------------------------------------------------------------------
    logic [COUNT_BITS-1:0]      cnt_mem [SLOT_TOTAL];
    logic signed [SUM_BITS-1:0] sum_mem [SLOT_TOTAL];
    logic signed [ERR_BITS-1:0] max_mem [SLOT_TOTAL];

    logic [COUNT_BITS-1:0]      rd_cnt_reg;
    logic signed [SUM_BITS-1:0] rd_sum_reg;
    logic signed [ERR_BITS-1:0] rd_max_reg;

    // stage 1 registers
    nwes_op_t                   s1_op_reg;
    logic [1:0]                 s1_kind_reg;
    logic [SLOT_BITS-1:0]       s1_slot_reg;
    logic                       s1_row_reg;
    logic [IDX_BITS-1:0]        s1_idx_reg;
    logic signed [ERR_BITS-1:0] s1_total_reg;
    logic                       s1_hit_reg;
    logic                       s1_drop_reg;
    logic                       s1_fwd_reg;
    logic [COUNT_BITS-1:0]      fwd_cnt_reg;
    logic signed [SUM_BITS-1:0] fwd_sum_reg;
    logic signed [ERR_BITS-1:0] fwd_max_reg;

    // operands: forwarded when the request ahead wrote this slot
    logic [COUNT_BITS-1:0]      op_cnt;
    logic signed [SUM_BITS-1:0] op_sum;
    logic signed [ERR_BITS-1:0] op_max;
    logic [COUNT_BITS-1:0]      new_cnt;
    logic signed [SUM_BITS-1:0] new_sum;
    logic signed [ERR_BITS-1:0] new_max;

    assign op_cnt = s1_fwd_reg ? fwd_cnt_reg : rd_cnt_reg;
    assign op_sum = s1_fwd_reg ? fwd_sum_reg : rd_sum_reg;
    assign op_max = s1_fwd_reg ? fwd_max_reg : rd_max_reg;

    assign s1_write = s1_commit && (s1_op_reg == OP_SAMPLE) && !s1_drop_reg;

    nwes_slot_update #(
        .COUNT_BITS (COUNT_BITS)
    ) u_slot_update (
        .hit     (s1_hit_reg),
        .cnt_in  (op_cnt),
        .sum_in  (op_sum),
        .max_in  (op_max),
        .total   (s1_total_reg),
        .cnt_out (new_cnt),
        .sum_out (new_sum),
        .max_out (new_max)
    );

    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            cnt_mem[s1_idx_reg] <= new_cnt;
            sum_mem[s1_idx_reg] <= new_sum;
            max_mem[s1_idx_reg] <= new_max;
        end
        if (accept)
        begin
            rd_cnt_reg <= cnt_mem[a_idx];
            rd_sum_reg <= sum_mem[a_idx];
            rd_max_reg <= max_mem[a_idx];
        end
    end

    // ---------------------------------------------------------------------
    // stage 1 and response registers
    // ---------------------------------------------------------------------
    nwes_rsp_t rsp_data_next;
    nwes_rsp_t rsp_data_reg;

    always_comb
    begin
        rsp_data_next               = '0;
        rsp_data_next.page_kind     = s1_kind_reg;
        rsp_data_next.wordline_slot = s1_slot_reg;
        rsp_data_next.slot_row      = s1_row_reg;
        unique case (s1_op_reg)
            OP_SAMPLE:
            begin
                if (s1_drop_reg)
                    rsp_data_next.dropped = 1'b1;
                else
                begin
                    rsp_data_next.slot_count = OUT_CNT_BITS'(new_cnt);
                    rsp_data_next.slot_sum   = new_sum;
                    rsp_data_next.slot_max   = new_max;
                end
            end
            OP_READ:
            begin
                if (s1_hit_reg)
                begin
                    rsp_data_next.slot_count = OUT_CNT_BITS'(op_cnt);
                    rsp_data_next.slot_sum   = op_sum;
                    rsp_data_next.slot_max   = op_max;
                end
            end
            OP_START, OP_CLEAR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_commit)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (s1_commit)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= a_op;
            s1_kind_reg  <= a_kind;
            s1_slot_reg  <= a_slot;
            s1_row_reg   <= a_row;
            s1_idx_reg   <= a_idx;
            s1_total_reg <= a_total;
            s1_hit_reg   <= a_hit;
            s1_drop_reg  <= a_drop;
            s1_fwd_reg   <= s1_write && (s1_idx_reg == a_idx);
            fwd_cnt_reg  <= new_cnt;
            fwd_sum_reg  <= new_sum;
            fwd_max_reg  <= new_max;
        end
        if (s1_commit)
            rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule
